[sv/caof_pkg.sv]
// ----------------------------------------------------------------------------
// caof_pkg
// Shared types and constants of the cascaded sparse-lag operator filter.
// ----------------------------------------------------------------------------
package caof_pkg;

	// fixed field widths
	localparam int SAMPLE_W = 32;
	localparam int COEF_W   = 16;
	localparam int LAG_W    = 6;
	localparam int BOUND_W  = 4;
	localparam int NUM_BOUNDS = 5;
	localparam int REG_TERMS  = 8;
	localparam int FRAC_SHIFT = 14;
	localparam int ACC_W    = 40;
	localparam int PROD_W   = SAMPLE_W + COEF_W;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;
	localparam int INDEX_W  = 16;

	// parameter defaults
	localparam int DEF_MAX_OPERATORS = 4;
	localparam int DEF_MAX_TERMS     = 8;
	localparam int DEF_MAX_LAG       = 32;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_FIRST_OP  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_OP   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BOUNDS    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LAGS      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEFS_LO  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEFS_HI  = 3'd5;

	localparam logic [19:0] BOUNDS_RESET = 20'h11111;

	// cell sequencer states
	typedef enum logic [2:0] {
		C_IDLE,
		C_SCAN,
		C_MUL,
		C_ACC,
		C_DONE,
		C_PASS
	} cell_state_t;

	// input word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] sample;
		logic                       first;
	} smp_word_t;

	// result word
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] value;
		logic [INDEX_W-1:0]         out_index;
		logic                       saturated;
	} res_word_t;

endpackage

[sv/caof_cell.sv]
// ----------------------------------------------------------------------------
// caof_cell
// One operator of the cascade: delay ring, fill count and a term sequencer
// that walks the operator's terms with one multiply per term.
// ----------------------------------------------------------------------------
module caof_cell #(
	parameter int MAX_TERMS = caof_pkg::DEF_MAX_TERMS,
	parameter int MAX_LAG   = caof_pkg::DEF_MAX_LAG
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic [caof_pkg::BOUND_W-1:0]          bnd_lo,
	input  logic [caof_pkg::BOUND_W-1:0]          bnd_hi,
	input  logic [caof_pkg::REG_TERMS*caof_pkg::LAG_W-1:0]  term_lags,
	input  logic [caof_pkg::REG_TERMS*caof_pkg::COEF_W-1:0] coefs,
	input  logic                                  clr,
	input  logic                                  go,
	input  logic signed [caof_pkg::SAMPLE_W-1:0]  x_in,
	input  logic                                  sat_in,
	output logic                                  out_go,
	output logic signed [caof_pkg::SAMPLE_W-1:0]  out_x,
	output logic                                  out_sat,
	output logic                                  drop,
	output logic                                  active
);

	localparam int AW  = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
	localparam int FW  = $clog2(MAX_LAG + 1);
	localparam int TW  = $clog2(MAX_TERMS + 1);
	localparam int TIW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
	localparam logic signed [caof_pkg::ACC_W-1:0] SAT_HI =
		caof_pkg::ACC_W'((64'sd1 <<< (caof_pkg::SAMPLE_W - 1)) - 64'sd1);
	localparam logic signed [caof_pkg::ACC_W-1:0] SAT_LO = -SAT_HI - 1;

	caof_pkg::cell_state_t state_q, state_d;

	logic [caof_pkg::SAMPLE_W-1:0]        ring_q [MAX_LAG];
	logic [AW-1:0]                        wr_q;
	logic [FW-1:0]                        fill_q;
	logic [FW-1:0]                        fill_now;
	logic [TW-1:0]                        t_q;
	logic signed [caof_pkg::SAMPLE_W-1:0] x_q;
	logic signed [caof_pkg::SAMPLE_W-1:0] rd_q;
	logic signed [caof_pkg::PROD_W-1:0]   prod_q;
	logic signed [caof_pkg::ACC_W-1:0]    acc_q;
	logic                                 sat_q;
	logic                                 emit_q;

	logic [MAX_TERMS-1:0]                 mask;
	logic [FW-1:0]                        lag_c [MAX_TERMS];
	logic [FW-1:0]                        mx;
	logic [TIW-1:0]                       ti;
	logic [FW-1:0]                        cur_lag;
	logic signed [caof_pkg::COEF_W-1:0]   cur_coef;
	logic [7:0]                           rd_sum;
	logic [AW-1:0]                        rd_addr;
	logic signed [caof_pkg::SAMPLE_W-1:0] past;
	logic                                 clip_hi;
	logic                                 clip_lo;

	// term membership, clamped lags and the largest lag
	always_comb begin
		logic [caof_pkg::LAG_W-1:0] raw;
		logic [caof_pkg::BOUND_W-1:0] tnum;
		mx = '0;
		for (int i = 0; i < MAX_TERMS; i++) begin
			tnum = caof_pkg::BOUND_W'(i + 1);
			raw = term_lags[i*caof_pkg::LAG_W +: caof_pkg::LAG_W];
			mask[i] = (tnum >= bnd_lo) && (tnum < bnd_hi);
			lag_c[i] = (raw > caof_pkg::LAG_W'(MAX_LAG)) ? FW'(MAX_LAG) : FW'(raw);
			if (mask[i] && (lag_c[i] > mx)) begin
				mx = lag_c[i];
			end
		end
	end

	// current term selection and ring read address
	assign ti       = t_q[TIW-1:0];
	assign cur_lag  = lag_c[ti];
	assign cur_coef = coefs[32'(ti)*caof_pkg::COEF_W +: caof_pkg::COEF_W];
	assign rd_sum   = (8'(wr_q) >= 8'(cur_lag)) ? (8'(wr_q) - 8'(cur_lag))
		: (8'(wr_q) + 8'(MAX_LAG) - 8'(cur_lag));
	assign rd_addr  = rd_sum[AW-1:0];
	assign fill_now = clr ? '0 : fill_q;
	assign past     = (cur_lag == '0) ? x_q : rd_q;
	assign clip_hi  = acc_q > SAT_HI;
	assign clip_lo  = acc_q < SAT_LO;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= caof_pkg::C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and handoff outputs
	always_comb begin
		state_d = state_q;
		out_go  = 1'b0;
		drop    = 1'b0;
		out_x   = x_q;
		out_sat = sat_q;
		case (state_q)
			caof_pkg::C_IDLE: begin
				if (go) begin
					if (!en) begin
						state_d = caof_pkg::C_PASS;
					end else if (fill_now < mx) begin
						state_d = caof_pkg::C_DONE;
					end else begin
						state_d = caof_pkg::C_SCAN;
					end
				end
			end
			caof_pkg::C_SCAN: begin
				if (t_q == TW'(MAX_TERMS)) begin
					state_d = caof_pkg::C_DONE;
				end else if (mask[ti]) begin
					state_d = caof_pkg::C_MUL;
				end
			end
			caof_pkg::C_MUL: state_d = caof_pkg::C_ACC;
			caof_pkg::C_ACC: state_d = caof_pkg::C_SCAN;
			caof_pkg::C_DONE: begin
				state_d = caof_pkg::C_IDLE;
				out_go  = emit_q;
				drop    = !emit_q;
				out_sat = sat_q | clip_hi | clip_lo;
				out_x   = clip_hi ? SAT_HI[caof_pkg::SAMPLE_W-1:0]
					: clip_lo ? SAT_LO[caof_pkg::SAMPLE_W-1:0]
					: acc_q[caof_pkg::SAMPLE_W-1:0];
			end
			caof_pkg::C_PASS: begin
				state_d = caof_pkg::C_IDLE;
				out_go  = 1'b1;
			end
			default: state_d = caof_pkg::C_IDLE;
		endcase
	end

	assign active = (state_q != caof_pkg::C_IDLE);

	// fill count and write pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			wr_q   <= '0;
		end else if (state_q == caof_pkg::C_DONE) begin
			wr_q <= (wr_q == AW'(MAX_LAG - 1)) ? '0 : wr_q + 1'b1;
			if (fill_q < FW'(MAX_LAG)) begin
				fill_q <= fill_q + 1'b1;
			end
		end else if (clr) begin
			fill_q <= '0;
		end
	end

	// delay ring
	always_ff @(posedge clk) begin
		if (state_q == caof_pkg::C_DONE) begin
			ring_q[wr_q] <= x_q;
		end
		if (state_q == caof_pkg::C_SCAN) begin
			rd_q <= ring_q[rd_addr];
		end
	end

	// datapath: term walk, multiply, accumulate
	always_ff @(posedge clk) begin
		case (state_q)
			caof_pkg::C_IDLE: begin
				if (go) begin
					x_q    <= x_in;
					sat_q  <= sat_in;
					acc_q  <= caof_pkg::ACC_W'(x_in);
					t_q    <= '0;
					emit_q <= (fill_now >= mx);
				end
			end
			caof_pkg::C_SCAN: begin
				if ((t_q != TW'(MAX_TERMS)) && !mask[ti]) begin
					t_q <= t_q + 1'b1;
				end
			end
			caof_pkg::C_MUL: prod_q <= past * cur_coef;
			caof_pkg::C_ACC: begin
				acc_q <= acc_q - caof_pkg::ACC_W'(prod_q >>> caof_pkg::FRAC_SHIFT);
				t_q   <= t_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

[sv/cascaded_ar_operator_filter_unit.sv]
// ----------------------------------------------------------------------------
// cascaded_ar_operator_filter_unit
// Cascade of sparse-lag operators y = x - sum coef*x[t-lag] over a sample
// series, with per-stage saturation.
// ----------------------------------------------------------------------------
// Usage:
//  smp_* moves one sample word; first=1 starts a new series and clears every
//  stage fill count and the output index. res_* moves one result word; a
//  sample yields none while a selected stage has not seen its largest lag.
//  cfg_* writes the six registers; write only while the block is idle.
//  The cells run one after another. A disabled cell goes straight to its
//  pass state, a not yet filled one straight to its done state; a filled
//  cell scans every term slot, does a multiply and an accumulate per term
//  and then finishes. The result word passes through the pending register
//  and then the output register. One sample is in flight at a time: the
//  block takes no new sample until the last one is loaded or dropped.
//  smp_stall is high while a sample is in flight. A finished word waits on
//  res_stall in the output register while the next sample runs; a second
//  one holds smp_stall high until the register frees.
//  Reset restores registers, fill counts and index; rings are read once filled.
// ----------------------------------------------------------------------------
module cascaded_ar_operator_filter_unit #(
	parameter int MAX_OPERATORS = caof_pkg::DEF_MAX_OPERATORS,
	parameter int MAX_TERMS     = caof_pkg::DEF_MAX_TERMS,
	parameter int MAX_LAG       = caof_pkg::DEF_MAX_LAG
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               smp_valid,
	output logic                               smp_stall,
	input  caof_pkg::smp_word_t                smp_word,
	output logic                               res_valid,
	input  logic                               res_stall,
	output caof_pkg::res_word_t                res_word,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [caof_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [caof_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [2:0]  first_op_q;
	logic [2:0]  last_op_q;
	logic [19:0] bounds_q;
	logic [47:0] lags_q;
	logic [63:0] coefs_lo_q;
	logic [63:0] coefs_hi_q;

	logic        busy_q;
	logic        pend_q;
	logic        res_valid_q;
	caof_pkg::res_word_t pend_word_q;
	caof_pkg::res_word_t res_word_q;
	logic [caof_pkg::INDEX_W-1:0] count_q;

	logic        smp_acc;
	logic        clr;
	logic        load;
	logic [3:0]  op_beg;
	logic [3:0]  op_end;

	logic [MAX_OPERATORS:0]                       go_c;
	logic signed [caof_pkg::SAMPLE_W-1:0]         x_c [MAX_OPERATORS+1];
	logic [MAX_OPERATORS:0]                       sat_c;
	logic [MAX_OPERATORS-1:0]                     drop_c;
	logic [MAX_OPERATORS-1:0]                     act_c;

	assign cfg_ready = 1'b1;
	assign smp_stall = busy_q;
	assign smp_acc   = smp_valid && !busy_q;
	assign clr       = smp_acc && smp_word.first;
	assign load      = pend_q && (!res_valid_q || !res_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_op_q <= 3'd1;
			last_op_q  <= 3'd0;
			bounds_q   <= caof_pkg::BOUNDS_RESET;
			lags_q     <= '0;
			coefs_lo_q <= '0;
			coefs_hi_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				caof_pkg::REG_FIRST_OP: first_op_q <= cfg_data[2:0];
				caof_pkg::REG_LAST_OP:  last_op_q  <= cfg_data[2:0];
				caof_pkg::REG_BOUNDS:   bounds_q   <= cfg_data[19:0];
				caof_pkg::REG_LAGS:     lags_q     <= cfg_data[47:0];
				caof_pkg::REG_COEFS_LO: coefs_lo_q <= cfg_data;
				caof_pkg::REG_COEFS_HI: coefs_hi_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// selected operator range
	assign op_beg = (first_op_q == 3'd0) ? 4'd1 : {1'b0, first_op_q};
	assign op_end = ({1'b0, last_op_q} > 4'(MAX_OPERATORS)) ? 4'(MAX_OPERATORS)
		: {1'b0, last_op_q};

	// head of the chain
	assign go_c[0]  = smp_acc;
	assign x_c[0]   = smp_word.sample;
	assign sat_c[0] = 1'b0;

	// chain of operator cells
	for (genvar i = 0; i < MAX_OPERATORS; i++) begin : g_cell
		localparam logic [3:0] OP = 4'(i + 1);
		logic [caof_pkg::BOUND_W-1:0] b_lo;
		logic [caof_pkg::BOUND_W-1:0] b_hi;
		if (i < caof_pkg::NUM_BOUNDS) begin : g_lo
			assign b_lo = bounds_q[i*caof_pkg::BOUND_W +: caof_pkg::BOUND_W];
		end else begin : g_lo0
			assign b_lo = '0;
		end
		if (i + 1 < caof_pkg::NUM_BOUNDS) begin : g_hi
			assign b_hi = bounds_q[(i+1)*caof_pkg::BOUND_W +: caof_pkg::BOUND_W];
		end else begin : g_hi0
			assign b_hi = '0;
		end
		caof_cell #(
			.MAX_TERMS (MAX_TERMS),
			.MAX_LAG   (MAX_LAG)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        ((OP >= op_beg) && (OP <= op_end)),
			.bnd_lo    (b_lo),
			.bnd_hi    (b_hi),
			.term_lags (lags_q),
			.coefs     ({coefs_hi_q, coefs_lo_q}),
			.clr       (clr),
			.go        (go_c[i]),
			.x_in      (x_c[i]),
			.sat_in    (sat_c[i]),
			.out_go    (go_c[i+1]),
			.out_x     (x_c[i+1]),
			.out_sat   (sat_c[i+1]),
			.drop      (drop_c[i]),
			.active    (act_c[i])
		);
	end

	// flight control, output index and pending word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			pend_q  <= 1'b0;
			count_q <= '0;
		end else begin
			if (smp_acc) begin
				busy_q <= 1'b1;
				if (smp_word.first) begin
					count_q <= '0;
				end
			end else if ((|drop_c) || load) begin
				busy_q <= 1'b0;
			end
			if (go_c[MAX_OPERATORS]) begin
				pend_q <= 1'b1;
				if (count_q != '1) begin
					count_q <= count_q + 1'b1;
				end
			end else if (load) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go_c[MAX_OPERATORS]) begin
			pend_word_q.value     <= x_c[MAX_OPERATORS];
			pend_word_q.saturated <= sat_c[MAX_OPERATORS];
			pend_word_q.out_index <= (count_q != '1) ? count_q + 1'b1 : count_q;
		end
		if (load) begin
			res_word_q <= pend_word_q;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid = res_valid_q;
	assign res_word  = res_word_q;

	// checks
	a_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		smp_acc |=> busy_q) else $error("sample accepted but not in flight");
	a_pend_busy: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> busy_q) else $error("pending word without flight");
	a_one_cell: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(act_c)) else $error("more than one cell working");
	a_idle_cells: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (act_c == '0)) else $error("cell working while idle");

endmodule

[tb/tb_cascaded_ar_operator_filter_unit.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_cascaded_ar_operator_filter_unit
// Self-checking bench for the cascaded sparse-lag operator filter: random and
// directed sample series under several register settings, every result word
// compared against a built-in predictor, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_cascaded_ar_operator_filter_unit;

	localparam int N_OPS   = caof_pkg::DEF_MAX_OPERATORS;
	localparam int N_TERMS = caof_pkg::DEF_MAX_TERMS;
	localparam int LAG_CAP = caof_pkg::DEF_MAX_LAG;
	localparam int SETTLE_CYCLES = 250;

	logic                            clk;
	logic                            arst_n;
	logic                            smp_valid;
	logic                            smp_stall;
	caof_pkg::smp_word_t             smp_word;
	logic                            res_valid;
	logic                            res_stall;
	caof_pkg::res_word_t             res_word;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [caof_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [caof_pkg::CFG_DATA_W-1:0] cfg_data;

	cascaded_ar_operator_filter_unit dut (
		.clk(clk), .arst_n(arst_n),
		.smp_valid(smp_valid), .smp_stall(smp_stall), .smp_word(smp_word),
		.res_valid(res_valid), .res_stall(res_stall), .res_word(res_word),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow copy of the registers
	logic [2:0]  op_lo_q;
	logic [2:0]  op_hi_q;
	logic [19:0] bounds_q;
	logic [47:0] lags_q;
	logic [63:0] coefs_lo_q;
	logic [63:0] coefs_hi_q;

	// shadow copy of the filter state
	longint  ring_q [N_OPS][LAG_CAP];
	int      fill_q [N_OPS];
	int      wptr_q [N_OPS];
	int      index_q;

	caof_pkg::res_word_t pending_words[$];
	int fail_count;
	int n_samples;
	int n_results;
	int n_clipped;
	int tx_idle_pct;
	int rx_idle_pct;

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial begin
		#10ms;
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int bound_at(input int k);
		if (k > 4) return 0;
		return int'(bounds_q[4*k +: 4]);
	endfunction

	function automatic int lag_at(input int t);
		int l;
		l = int'(lags_q[6*(t-1) +: 6]);
		return (l > LAG_CAP) ? LAG_CAP : l;
	endfunction

	function automatic longint coef_at(input int t);
		logic [63:0] w;
		w = (t <= 4) ? coefs_lo_q : coefs_hi_q;
		return longint'($signed(w[16*((t-1)%4) +: 16]));
	endfunction

	// one operator stage; returns 1 when it emits
	function automatic bit run_operator(input int op, input longint xin,
			output longint yout, inout bit clip);
		int s, b0, b1, mx, lag;
		bit emit;
		longint acc, past, hi_lim, lo_lim;
		s = op - 1;
		b0 = bound_at(op - 1);
		b1 = bound_at(op);
		mx = 0;
		hi_lim = 64'sd2147483647;
		lo_lim = -64'sd2147483648;
		yout = 0;
		for (int t = b0; t < b1; t++)
			if (t >= 1 && t <= N_TERMS && lag_at(t) > mx) mx = lag_at(t);
		emit = fill_q[s] >= mx;
		if (emit) begin
			acc = xin;
			for (int t = b0; t < b1; t++) begin
				if (t < 1 || t > N_TERMS) continue;
				lag = lag_at(t);
				past = (lag == 0) ? xin : ring_q[s][(wptr_q[s] + LAG_CAP - lag) % LAG_CAP];
				acc -= (past * coef_at(t)) >>> caof_pkg::FRAC_SHIFT;
			end
			if (acc > hi_lim) begin
				acc = hi_lim;
				clip = 1'b1;
			end
			if (acc < lo_lim) begin
				acc = lo_lim;
				clip = 1'b1;
			end
			yout = acc;
		end
		ring_q[s][wptr_q[s]] = xin;
		wptr_q[s] = (wptr_q[s] + 1) % LAG_CAP;
		if (fill_q[s] < LAG_CAP) fill_q[s]++;
		return emit;
	endfunction

	// whole cascade for one accepted sample word
	function automatic void filter_sample(input caof_pkg::smp_word_t w);
		int op_beg, op_end;
		longint x, y;
		bit clip;
		caof_pkg::res_word_t r;
		x = longint'(w.sample);
		clip = 1'b0;
		op_beg = (op_lo_q == 0) ? 1 : int'(op_lo_q);
		op_end = (op_hi_q > N_OPS) ? N_OPS : int'(op_hi_q);
		if (w.first) begin
			foreach (fill_q[i]) fill_q[i] = 0;
			index_q = 0;
		end
		for (int op = op_beg; op <= op_end; op++) begin
			if (!run_operator(op, x, y, clip)) return;
			x = y;
		end
		if (index_q < 65535) index_q++;
		r.value = x[31:0];
		r.out_index = index_q[15:0];
		r.saturated = clip;
		pending_words.push_back(r);
	endfunction

	// send one sample word, with random idle cycles ahead of it
	task automatic send_sample(input logic [31:0] s, input logic first_flag);
		caof_pkg::smp_word_t w;
		w.sample = s;
		w.first = first_flag;
		while ($urandom_range(99) < tx_idle_pct) begin
			smp_valid <= 1'b0;
			@(posedge clk);
		end
		smp_valid <= 1'b1;
		smp_word <= w;
		do @(posedge clk); while (smp_stall);
		filter_sample(w);
		n_samples++;
	endtask

	task automatic write_reg(input logic [caof_pkg::CFG_IDX_W-1:0] idx,
			input logic [63:0] d);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			caof_pkg::REG_FIRST_OP: op_lo_q = d[2:0];
			caof_pkg::REG_LAST_OP:  op_hi_q = d[2:0];
			caof_pkg::REG_BOUNDS:   bounds_q = d[19:0];
			caof_pkg::REG_LAGS:     lags_q = d[47:0];
			caof_pkg::REG_COEFS_LO: coefs_lo_q = d;
			caof_pkg::REG_COEFS_HI: coefs_hi_q = d;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// wait for every expected word, then let the block settle
	task automatic drain;
		int guard;
		guard = 0;
		smp_valid <= 1'b0;
		while (pending_words.size() != 0 && guard < 200000) begin
			@(posedge clk);
			guard++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		caof_pkg::res_word_t e;
		if (arst_n && res_valid && !res_stall) begin
			if (pending_words.size() == 0) begin
				$error("unexpected result word value=%0d index=%0d",
					res_word.value, res_word.out_index);
				fail_count++;
			end else begin
				e = pending_words.pop_front();
				n_results++;
				if (e.saturated) n_clipped++;
				if (res_word.value !== e.value) begin
					$error("value: expected %0d, got %0d", e.value, res_word.value);
					fail_count++;
				end
				if (res_word.out_index !== e.out_index) begin
					$error("out_index: expected %0d, got %0d", e.out_index, res_word.out_index);
					fail_count++;
				end
				if (res_word.saturated !== e.saturated) begin
					$error("saturated: expected %0b, got %0b", e.saturated, res_word.saturated);
					fail_count++;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk)
		res_stall <= ($urandom_range(99) < rx_idle_pct);

	// reset values: pass-through, with extreme samples
	task automatic test_passthrough;
		send_sample(32'h7FFF_FFFF, 1'b1);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		drain();
	endtask

	// three operators with lag zero, skipped term zero, extreme coefficients
	task automatic test_directed_cascade;
		write_reg(caof_pkg::REG_FIRST_OP, 64'd1);
		write_reg(caof_pkg::REG_LAST_OP, 64'd3);
		// op1 terms 0..1 (term zero skipped), op2 terms 2..3, op3 terms 4..8
		write_reg(caof_pkg::REG_BOUNDS, 64'h9_9_4_2_0);
		write_reg(caof_pkg::REG_LAGS,
			64'({6'd4, 6'd3, 6'd2, 6'd1, 6'd2, 6'd3, 6'd1, 6'd0}));
		write_reg(caof_pkg::REG_COEFS_LO, {16'h7FFF, 16'h2000, 16'h7FFF, 16'h8000});
		write_reg(caof_pkg::REG_COEFS_HI, {16'hFFFF, 16'h0001, 16'h8000, 16'hC000});
		for (int i = 0; i < 12; i++)
			send_sample(i[0] ? 32'h8000_0000 : 32'h7FFF_FFFF, i == 0);
		send_sample(32'h0001_0000, 1'b1);
		for (int i = 0; i < 5; i++) send_sample($urandom, 1'b0);
		drain();
	endtask

	// register extremes: first taken as one, last clamped, empty operators
	task automatic test_register_extremes;
		write_reg(caof_pkg::REG_FIRST_OP, 64'd0);
		write_reg(caof_pkg::REG_LAST_OP, 64'd7);
		write_reg(caof_pkg::REG_BOUNDS, 64'hF_F_F_F_1);
		write_reg(caof_pkg::REG_LAGS, 64'hFFFF_FFFF_FFFF);
		for (int i = 0; i < 4; i++) send_sample($urandom, i == 0);
		drain();
	endtask

	// random registers, then series of random samples
	task automatic test_random_phase(input int tx, input int rx, input int n_items);
		logic [19:0] b;
		int nib, left;
		tx_idle_pct = tx;
		rx_idle_pct = rx;
		write_reg(caof_pkg::REG_FIRST_OP, 64'($urandom_range(0, 7)));
		write_reg(caof_pkg::REG_LAST_OP, 64'(($urandom_range(3) == 0)
			? $urandom_range(0, 7) : $urandom_range(2, 4)));
		if ($urandom_range(1)) begin
			nib = $urandom_range(0, 2);
			for (int k = 0; k < 5; k++) begin
				b[4*k +: 4] = nib[3:0];
				nib = nib + $urandom_range(0, 3);
				if (nib > 15) nib = 15;
			end
		end else b = 20'($urandom);
		write_reg(caof_pkg::REG_BOUNDS, 64'(b));
		write_reg(caof_pkg::REG_LAGS, {$urandom, $urandom} & (($urandom_range(1))
			? 64'hFFFF_FFFF_FFFF : 64'h1F7D_F7DF_7DF7));
		write_reg(caof_pkg::REG_COEFS_LO, {$urandom, $urandom});
		write_reg(caof_pkg::REG_COEFS_HI, {$urandom, $urandom});
		left = 0;
		for (int i = 0; i < n_items; i++) begin
			logic [31:0] s;
			case ($urandom_range(7))
				0: s = 32'h7FFF_FFFF;
				1: s = 32'h8000_0000;
				2: s = $urandom_range(0, 255) << 16;
				default: s = $urandom;
			endcase
			if (left == 0) left = $urandom_range(20, 160);
			send_sample(s, left == 1 || i == 0 || $urandom_range(199) == 0);
			left--;
		end
		drain();
	endtask

	initial begin
		arst_n <= 1'b0;
		smp_valid <= 1'b0;
		smp_word <= '0;
		res_stall <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_index <= caof_pkg::REG_FIRST_OP;
		cfg_data <= '0;
		fail_count = 0;
		n_samples = 0;
		n_results = 0;
		n_clipped = 0;
		tx_idle_pct = 13;
		rx_idle_pct = 88;
		op_lo_q = 3'd1;
		op_hi_q = 3'd0;
		bounds_q = caof_pkg::BOUNDS_RESET;
		lags_q = '0;
		coefs_lo_q = '0;
		coefs_hi_q = '0;
		foreach (fill_q[i]) begin
			fill_q[i] = 0;
			wptr_q[i] = 0;
		end
		foreach (ring_q[i, j]) ring_q[i][j] = 0;
		index_q = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_passthrough();
		test_directed_cascade();
		test_register_extremes();
		for (int p = 0; p < 9; p++) begin
			case (p / 3)
				0: test_random_phase(13, 88, 88);
				1: test_random_phase(88, 13, 88);
				default: test_random_phase(0, 0, 88);
			endcase
		end

		$display("covered %0d samples over 12 register settings and three idling modes",
			n_samples);
		$display("checked %0d result words, %0d of them clipped", n_results, n_clipped);
		if (fail_count == 0 && pending_words.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
